// ----- hdl/vesw_pkg.sv -----
// ----------------------------------------------------------------------------
// vesw_pkg
// Shared types and constants of the velocity EMA smoother with watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

package vesw_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    OP_CMD  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_ALPHA_LIN  = 2'd0,
    REG_ALPHA_ANG  = 2'd1,
    REG_STOP_LIMIT = 2'd2,
    REG_NONE       = 2'd3
  } reg_idx_t;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int                STOP_W         = 16;
  localparam logic [STOP_W-1:0] STOP_LIMIT_RST = 16'd30;

endpackage : vesw_pkg

`default_nettype wire

// ----- hdl/velocity_ema_smoother_watchdog.sv -----
// ----------------------------------------------------------------------------
// velocity_ema_smoother_watchdog
// Three-channel velocity EMA smoother with a command watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): an item is either a velocity
//   command (in_operation = command) or a timer tick. A command loads the
//   held x, y and turn values and reloads the watchdog from stop_limit; it
//   gives no result. A tick runs the watchdog and the three EMA channels and
//   gives one result on the output channel (out_valid / out_stall).
//   A tick is captured in the input register and shows its result once the
//   result register loads. Throughput: one item per cycle while no tick
//   is held back by out_stall; the EMA state is updated through one
//   combinational multiply-add per channel.
//   While out_stall holds a result, commands keep flowing; a tick waits in
//   the input register and in_stall rises until the result is taken.
//   Reset (synchronous, rst_n low): weights return to one, stop_limit and
//   the countdown to 30, all held and last values to zero, both pipeline
//   registers empty.
//   Registers over APB at byte addresses 0, 4, 8: alpha_linear,
//   alpha_angular, stop_limit. Write them only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_ema_smoother_watchdog #(
  parameter int VEL_WIDTH       = 16,
  parameter int ALPHA_FRAC_BITS = 15
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_operation,
  input  wire logic signed [VEL_WIDTH-1:0]     in_cmd_x,
  input  wire logic signed [VEL_WIDTH-1:0]     in_cmd_y,
  input  wire logic signed [VEL_WIDTH-1:0]     in_cmd_turn,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed      [VEL_WIDTH-1:0]     out_x,
  output logic signed      [VEL_WIDTH-1:0]     out_y,
  output logic signed      [VEL_WIDTH-1:0]     out_turn,
  output logic                                 out_timed_out,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [vesw_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [vesw_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [vesw_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);

  logic [ALPHA_FRAC_BITS:0]     alpha_lin_eff, alpha_ang_eff;
  logic [vesw_pkg::STOP_W-1:0]  stop_limit;

  vesw_cfg_regs #(
    .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .alpha_lin_eff (alpha_lin_eff),
    .alpha_ang_eff (alpha_ang_eff),
    .stop_limit    (stop_limit)
  );

  // input register
  logic                        s1_valid_r, s1_valid_nxt;
  vesw_pkg::op_t               s1_op_r;
  logic signed [VEL_WIDTH-1:0] s1_x_r, s1_y_r, s1_turn_r;

  // smoother state
  logic signed [VEL_WIDTH-1:0] held_x_r, held_y_r, held_turn_r;
  logic signed [VEL_WIDTH-1:0] last_x_r, last_y_r, last_turn_r;
  logic [vesw_pkg::STOP_W-1:0] countdown_r;

  // result register
  logic                        out_valid_r, out_valid_nxt;
  logic signed [VEL_WIDTH-1:0] out_x_r, out_y_r, out_turn_r;
  logic                        out_timed_out_r;

  logic                        in_take, s1_go, tick_fire, cmd_fire, expired;
  logic signed [VEL_WIDTH-1:0] src_x, src_y, src_turn;
  logic signed [VEL_WIDTH-1:0] ema_x, ema_y, ema_turn;

  // A command never needs the result register, so only ticks wait on it.
  assign s1_go     = s1_valid_r && ((s1_op_r == vesw_pkg::OP_CMD) ||
                                    !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_take   = in_valid && !in_stall;
  assign tick_fire = s1_go && (s1_op_r == vesw_pkg::OP_TICK);
  assign cmd_fire  = s1_go && (s1_op_r == vesw_pkg::OP_CMD);

  assign s1_valid_nxt  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = tick_fire || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= vesw_pkg::op_t'(in_operation);
      s1_x_r    <= in_cmd_x;
      s1_y_r    <= in_cmd_y;
      s1_turn_r <= in_cmd_turn;
    end
  end

  // watchdog: an expired countdown zeroes the held command for this tick
  assign expired  = (countdown_r == '0);
  assign src_x    = expired ? '0 : held_x_r;
  assign src_y    = expired ? '0 : held_y_r;
  assign src_turn = expired ? '0 : held_turn_r;

  vesw_ema_blend #(
    .VEL_WIDTH (VEL_WIDTH), .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_blend_x (
    .alpha (alpha_lin_eff), .held (src_x), .last (last_x_r), .result (ema_x)
  );

  vesw_ema_blend #(
    .VEL_WIDTH (VEL_WIDTH), .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_blend_y (
    .alpha (alpha_lin_eff), .held (src_y), .last (last_y_r), .result (ema_y)
  );

  vesw_ema_blend #(
    .VEL_WIDTH (VEL_WIDTH), .ALPHA_FRAC_BITS (ALPHA_FRAC_BITS)
  ) u_blend_turn (
    .alpha (alpha_ang_eff), .held (src_turn), .last (last_turn_r), .result (ema_turn)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r    <= '0;
      held_y_r    <= '0;
      held_turn_r <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_turn_r <= '0;
      countdown_r <= vesw_pkg::STOP_LIMIT_RST;
    end else if (cmd_fire) begin
      held_x_r    <= s1_x_r;
      held_y_r    <= s1_y_r;
      held_turn_r <= s1_turn_r;
      countdown_r <= stop_limit;
    end else if (tick_fire) begin
      held_x_r    <= ema_x;
      held_y_r    <= ema_y;
      held_turn_r <= ema_turn;
      last_x_r    <= ema_x;
      last_y_r    <= ema_y;
      last_turn_r <= ema_turn;
      countdown_r <= expired ? countdown_r : countdown_r - vesw_pkg::STOP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_x_r         <= ema_x;
      out_y_r         <= ema_y;
      out_turn_r      <= ema_turn;
      out_timed_out_r <= expired;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_turn      = out_turn_r;
  assign out_timed_out = out_timed_out_r;

  // a new result only ever follows a tick leaving the input register
  a_result_from_tick : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(tick_fire))
    else $error("result appeared without a tick");

  // an expired tick must be flagged on the result it produces
  a_timeout_flag : assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire && expired |=> out_timed_out_r && (countdown_r == '0))
    else $error("expired tick not flagged or countdown moved");

  // after a tick the held command tracks the smoothed output
  a_held_tracks_last : assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> (held_x_r == last_x_r) && (held_y_r == last_y_r) &&
                  (held_turn_r == last_turn_r) && (out_x_r == last_x_r))
    else $error("held state diverged from smoothed output");

endmodule : velocity_ema_smoother_watchdog

`default_nettype wire

// ----- hdl/vesw_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// vesw_cfg_regs
// APB register file: two EMA weights and the watchdog stop limit. Weights
// above one are clamped to one on their way to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module vesw_cfg_regs #(
  parameter int ALPHA_FRAC_BITS = 15
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [vesw_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [vesw_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [vesw_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output logic      [ALPHA_FRAC_BITS:0]           alpha_lin_eff,
  output logic      [ALPHA_FRAC_BITS:0]           alpha_ang_eff,
  output logic      [vesw_pkg::STOP_W-1:0]        stop_limit
);

  localparam logic [vesw_pkg::CFG_DATA_W-1:0] ALPHA_ONE =
    vesw_pkg::CFG_DATA_W'(1) << ALPHA_FRAC_BITS;

  logic [vesw_pkg::CFG_DATA_W-1:0] alpha_lin_r, alpha_lin_nxt;
  logic [vesw_pkg::CFG_DATA_W-1:0] alpha_ang_r, alpha_ang_nxt;
  logic [vesw_pkg::STOP_W-1:0]     stop_limit_r, stop_limit_nxt;
  logic                            wr_en;
  vesw_pkg::reg_idx_t              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = vesw_pkg::reg_idx_t'(paddr[3:2]);

  always_comb begin
    alpha_lin_nxt  = alpha_lin_r;
    alpha_ang_nxt  = alpha_ang_r;
    stop_limit_nxt = stop_limit_r;
    if (wr_en) begin
      case (idx)
        vesw_pkg::REG_ALPHA_LIN:  alpha_lin_nxt  = pwdata;
        vesw_pkg::REG_ALPHA_ANG:  alpha_ang_nxt  = pwdata;
        vesw_pkg::REG_STOP_LIMIT: stop_limit_nxt = pwdata[vesw_pkg::STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_lin_r  <= ALPHA_ONE;
      alpha_ang_r  <= ALPHA_ONE;
      stop_limit_r <= vesw_pkg::STOP_LIMIT_RST;
    end else begin
      alpha_lin_r  <= alpha_lin_nxt;
      alpha_ang_r  <= alpha_ang_nxt;
      stop_limit_r <= stop_limit_nxt;
    end
  end

  always_comb begin
    case (idx)
      vesw_pkg::REG_ALPHA_LIN:  prdata = alpha_lin_r;
      vesw_pkg::REG_ALPHA_ANG:  prdata = alpha_ang_r;
      vesw_pkg::REG_STOP_LIMIT: prdata = {{(vesw_pkg::CFG_DATA_W-vesw_pkg::STOP_W){1'b0}},
                                          stop_limit_r};
      default:                  prdata = '0;
    endcase
  end

  assign alpha_lin_eff = (alpha_lin_r > ALPHA_ONE) ? ALPHA_ONE[ALPHA_FRAC_BITS:0]
                                                   : alpha_lin_r[ALPHA_FRAC_BITS:0];
  assign alpha_ang_eff = (alpha_ang_r > ALPHA_ONE) ? ALPHA_ONE[ALPHA_FRAC_BITS:0]
                                                   : alpha_ang_r[ALPHA_FRAC_BITS:0];
  assign stop_limit    = stop_limit_r;

endmodule : vesw_cfg_regs

`default_nettype wire

// ----- hdl/vesw_ema_blend.sv -----
// ----------------------------------------------------------------------------
// vesw_ema_blend
// One EMA channel: last + alpha*(held - last), rounded half up, one multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module vesw_ema_blend #(
  parameter int VEL_WIDTH       = 16,
  parameter int ALPHA_FRAC_BITS = 15
) (
  input  wire logic        [ALPHA_FRAC_BITS:0] alpha,
  input  wire logic signed [VEL_WIDTH-1:0]     held,
  input  wire logic signed [VEL_WIDTH-1:0]     last,
  output logic signed      [VEL_WIDTH-1:0]     result
);

  localparam int DW = VEL_WIDTH + 1;
  localparam int AW = ALPHA_FRAC_BITS + 2;
  localparam int PW = AW + DW;
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] HALF = SW'(1) << (ALPHA_FRAC_BITS - 1);

  logic signed [DW-1:0] diff;
  logic signed [AW-1:0] alpha_s;
  logic signed [PW-1:0] prod;
  logic        [SW-1:0] last_scaled;
  logic        [SW-1:0] sum;

  assign diff    = {held[VEL_WIDTH-1], held} - {last[VEL_WIDTH-1], last};
  assign alpha_s = {1'b0, alpha};
  assign prod    = PW'(alpha_s) * PW'(diff);

  assign last_scaled = {{(SW-VEL_WIDTH-ALPHA_FRAC_BITS){last[VEL_WIDTH-1]}},
                        last, {ALPHA_FRAC_BITS{1'b0}}};
  assign sum = {prod[PW-1], prod} + last_scaled + HALF;

  // Taking bits above the fraction is a floor; the blend stays between held
  // and last, so the low VEL_WIDTH bits carry the whole value.
  assign result = sum[ALPHA_FRAC_BITS +: VEL_WIDTH];

endmodule : vesw_ema_blend

`default_nettype wire
